// ===== src/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared constants and types of the generational slot allocator: pool size,
// field widths, status codes and the control structs of the free stack.
// ----------------------------------------------------------------------------
package gsa_pkg;

	// Pool geometry.
	localparam int SLOT_COUNT  = 1024;
	localparam int IDX_W       = $clog2(SLOT_COUNT);
	localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
	localparam int GEN_BITS    = 32;

	// Fixed widths of the stream fields.
	localparam int IDX_FIELD_W = 10;
	localparam int GEN_FIELD_W = 32;
	localparam int TDATA_W     = 48;

	// Request kinds.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_STALE   = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Commands from the sequencer to the free stack.
	typedef struct packed {
		logic             rd;        // Fetch the entry below the top.
		logic             push;
		logic             pop;
		logic [IDX_W-1:0] push_idx;
	} stk_cmd_t;

	// State of the free stack seen by the sequencer.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] top;
	} stk_sts_t;

endpackage

// ===== src/generational_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator_core
// Hands out slot handles (index plus generation) and takes them back.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream. s_tuser is the operation (0 allocate,
//   1 free); s_tdata carries the handle to free (index and generation) and is
//   ignored on allocate. Every request yields exactly one result on the m_
//   stream: m_tuser is the status (ok, pool full, stale handle, index never
//   allocated), m_tdata the granted handle, zero unless an allocate succeeds.
//   Each request passes through the idle state, which reads the generation
//   memory (and the free-stack memory), and the exec state, which checks,
//   writes back and registers the result; a new request is taken only once
//   the previous one has left the exec state.
//   The result sits in an output register; the next request is taken while
//   it waits. If the receiver stalls, the following request holds in the
//   exec state until the output register frees, and s_tready stays low.
//   Reset clears the counts at once; no clearing pass runs. Slots at or above
//   the high-water mark are known to hold generation zero, so their memory
//   entries are never used before being written.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core
	import gsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [9:0] slot_index, [41:10] handle_generation
	input  logic               s_tuser,   // [0] operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [9:0] granted_index, [41:10] granted_generation
	output logic [1:0]         m_tuser    // [1:0] status
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t               state_q;
	logic                 accept;
	logic                 go;

	logic                 op_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [GEN_FIELD_W-1:0] hgen_s1;

	logic [GEN_BITS-1:0]  gen_mem [SLOT_COUNT];
	logic [GEN_BITS-1:0]  gen_rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 gen_we;
	logic [IDX_W-1:0]     gen_waddr;
	logic [GEN_BITS-1:0]  gen_wdata;

	logic [CNT_W-1:0]     hwm_q;
	logic                 hwm_inc;

	stk_cmd_t             stk_cmd;
	stk_sts_t             stk_sts;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [GEN_BITS-1:0]  out_gen_q;

	status_t              res_status;
	logic [IDX_W-1:0]     res_idx;
	logic [GEN_BITS-1:0]  res_gen;

	// Handshake: a request is taken in idle; the exec state waits for room.
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign go       = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: if (go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= s_tuser;
			idx_s1  <= s_tdata[IDX_FIELD_W-1:0];
			hgen_s1 <= s_tdata[IDX_FIELD_W +: GEN_FIELD_W];
		end
	end

	// Generation read address: the candidate slot on allocate, the handle's
	// slot on free.
	always_comb begin
		if (s_tuser == OP_FREE) begin
			rd_addr = s_tdata[IDX_FIELD_W-1:0];
		end else if (stk_sts.count != '0) begin
			rd_addr = stk_sts.top;
		end else begin
			rd_addr = hwm_q[IDX_W-1:0];
		end
	end

	// Generation memory.
	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_waddr] <= gen_wdata;
		end
		if (accept) begin
			gen_rd_q <= gen_mem[rd_addr];
		end
	end

	// Check the request against the read generation and build the result.
	always_comb begin
		res_status       = ST_OK;
		res_idx          = '0;
		res_gen          = '0;
		gen_we           = 1'b0;
		gen_waddr        = idx_s1;
		gen_wdata        = gen_rd_q + GEN_BITS'(1);
		hwm_inc          = 1'b0;
		stk_cmd.rd       = accept;
		stk_cmd.push     = 1'b0;
		stk_cmd.pop      = 1'b0;
		stk_cmd.push_idx = idx_s1;
		if (op_s1 == OP_ALLOC) begin
			priority if (stk_sts.count != '0) begin
				// Reuse the most recently freed slot; its generation advances by one.
				gen_we      = go;
				gen_waddr   = stk_sts.top;
				res_idx     = stk_sts.top;
				res_gen     = gen_rd_q + GEN_BITS'(1);
				stk_cmd.pop = go;
			end else if (hwm_q < CNT_W'(SLOT_COUNT)) begin
				// A fresh slot starts from generation zero.
				gen_we    = go;
				gen_waddr = hwm_q[IDX_W-1:0];
				gen_wdata = GEN_BITS'(1);
				res_idx   = hwm_q[IDX_W-1:0];
				res_gen   = GEN_BITS'(1);
				hwm_inc   = go;
			end else begin
				res_status = ST_FULL;
			end
		end else begin
			priority if (CNT_W'(idx_s1) >= hwm_q) begin
				res_status = ST_UNKNOWN;
			end else if (!gen_rd_q[0] || (GEN_FIELD_W'(gen_rd_q) != hgen_s1)) begin
				res_status = ST_STALE;
			end else begin
				// Live slot with a matching handle: retire it onto the stack.
				gen_we       = go;
				stk_cmd.push = go;
			end
		end
	end

	// High-water mark: number of slots ever handed out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= '0;
		end else if (hwm_inc) begin
			hwm_q <= hwm_q + CNT_W'(1);
		end
	end

	gsa_free_stack u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.sts    (stk_sts)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_status_q <= res_status;
			out_idx_q    <= res_idx;
			out_gen_q    <= res_gen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(TDATA_W - IDX_FIELD_W - GEN_FIELD_W){1'b0}},
		GEN_FIELD_W'(out_gen_q), IDX_FIELD_W'(out_idx_q)};

	// Every slot on the free stack was handed out at some point.
	a_count_le_hwm: assert property (@(posedge clk) disable iff (!arst_n)
		stk_sts.count <= hwm_q)
		else $error("free count above high-water mark");
	a_hwm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q <= CNT_W'(SLOT_COUNT))
		else $error("high-water mark beyond pool size");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request did not enter the check cycle");
	a_grant_live: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_OK) && (m_tdata[IDX_FIELD_W +: GEN_FIELD_W] != '0))
		|-> m_tdata[IDX_FIELD_W])
		else $error("granted generation is not live");

endmodule

// ===== src/gsa_free_stack.sv =====
// ----------------------------------------------------------------------------
// gsa_free_stack
// LIFO of freed slot indexes. The top entry is held in a register so that an
// allocate can use it at once; the entry below it is fetched from the memory
// when a request is taken and becomes the top on a pop.
// ----------------------------------------------------------------------------
module gsa_free_stack
	import gsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  stk_cmd_t cmd,
	output stk_sts_t sts
);

	logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
	logic [IDX_W-1:0] below_q;
	logic [IDX_W-1:0] top_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] below_addr;

	// Address of the entry under the top; wraps harmlessly when shallow.
	assign below_addr = count_q - CNT_W'(2);

	// Memory port: write on push, registered read of the entry below the top.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[count_q[IDX_W-1:0]] <= cmd.push_idx;
		end
		if (cmd.rd) begin
			below_q <= stack_mem[below_addr[IDX_W-1:0]];
		end
	end

	// Top register follows the pushed index or the fetched entry on pop.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.push_idx;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign sts.count = count_q;
	assign sts.top   = top_q;

	// The sequencer never pushes onto a full stack or pops an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < CNT_W'(SLOT_COUNT)))
		else $error("free stack push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("free stack pop while empty");
	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("free stack push and pop in one cycle");

endmodule

// ===== test/generational_slot_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator_core_tb
// Drives allocate and free requests into the slot allocator and checks every
// result against a cycle-free model of the pool. The model tracks each
// slot's generation, the free stack and the high-water mark. Directed
// requests cover the handle life cycle and the error statuses. Random traffic
// follows, then a long output stall and a run that exhausts the pool.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core_tb;
	import gsa_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int PAD_W       = TDATA_W - IDX_FIELD_W - GEN_FIELD_W;
	localparam logic [GEN_FIELD_W-1:0] GEN_MASK =
		(GEN_BITS >= GEN_FIELD_W) ? '1 : ((1 << GEN_BITS) - 1);

	// One expected result of a request.
	typedef struct packed {
		status_t                status;
		logic [IDX_FIELD_W-1:0] index;
		logic [GEN_FIELD_W-1:0] generation;
	} grant_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;   // [9:0] slot_index, [41:10] handle_generation
	logic               s_tuser = 1'b0; // [0] operation
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;        // [9:0] granted_index, [41:10] granted_generation
	logic [1:0]         m_tuser;        // [1:0] status

	// Pool model: generation per slot, free stack, count of slots ever issued.
	logic [GEN_FIELD_W-1:0] slot_generation [SLOT_COUNT];
	int                     recycled_slots [SLOT_COUNT];
	int                     recycled_count = 0;
	int                     issued_count = 0;
	int                     live_slots [$];

	grant_t expected_grants [$];
	int     error_count = 0;
	int     burst_left = 0;
	int     quiet_cycles = 0;
	bit     hold_off_request = 1'b0;

	generational_slot_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Apply one accepted request to the pool model and return its result.
	function automatic grant_t grant_for_request(input logic op,
			input logic [IDX_FIELD_W-1:0] idx, input logic [GEN_FIELD_W-1:0] gen);
		grant_t                 g;
		int                     slot;
		int                     pos;
		logic [GEN_FIELD_W-1:0] cur;
		g.status = ST_OK;
		g.index = '0;
		g.generation = '0;
		if (op == OP_ALLOC) begin
			// Reuse the most recently freed slot, else take a fresh one.
			if (recycled_count > 0) begin
				recycled_count--;
				slot = recycled_slots[recycled_count];
			end else if (issued_count < SLOT_COUNT) begin
				slot = issued_count;
				issued_count++;
			end else begin
				g.status = ST_FULL;
				return g;
			end
			slot_generation[slot] = (slot_generation[slot] + 1) & GEN_MASK;
			g.index = IDX_FIELD_W'(slot);
			g.generation = slot_generation[slot];
			live_slots.insert(live_slots.size(), slot);
		end else if (idx >= issued_count) begin
			g.status = ST_UNKNOWN;
		end else begin
			// A handle is valid only for a live slot with a matching generation.
			cur = slot_generation[idx];
			if (!cur[0] || cur != gen || recycled_count >= SLOT_COUNT) begin
				g.status = ST_STALE;
			end else begin
				slot_generation[idx] = (cur + 1) & GEN_MASK;
				recycled_slots[recycled_count] = idx;
				recycled_count++;
				pos = 0;
				foreach (live_slots[i])
					if (live_slots[i] == idx)
						pos = i;
				live_slots.delete(pos);
			end
		end
		return g;
	endfunction

	// Offer one request, in bursts with random gaps, and record its result
	// once the block takes it.
	task automatic send_request(input logic op, input logic [IDX_FIELD_W-1:0] idx,
			input logic [GEN_FIELD_W-1:0] gen);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{PAD_W{1'b0}}, gen, idx};
		do @(posedge clk); while (!s_tready);
		expected_grants.insert(expected_grants.size(), grant_for_request(op, idx, gen));
		burst_left--;
	endtask

	// One random request: allocates, well-formed frees of live handles, and
	// a share of bad handles.
	task automatic send_random_request(input int alloc_pct, input int free_pct);
		int                     pick;
		int                     slot;
		logic [IDX_FIELD_W-1:0] idx;
		logic [GEN_FIELD_W-1:0] gen;
		pick = $urandom_range(0, 99);
		idx = IDX_FIELD_W'($urandom);
		gen = $urandom;
		if (pick < alloc_pct) begin
			send_request(OP_ALLOC, idx, gen);
		end else if (pick < alloc_pct + free_pct && live_slots.size() > 0) begin
			slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
			send_request(OP_FREE, IDX_FIELD_W'(slot), slot_generation[slot]);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					// Live slot, one generation bit wrong.
					if (live_slots.size() > 0) begin
						slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
						idx = IDX_FIELD_W'(slot);
						gen = slot_generation[slot] ^ (32'd1 << $urandom_range(0, 31));
					end
				end
				1: begin
					// Previous generation of an issued slot.
					if (issued_count > 0) begin
						slot = $urandom_range(0, issued_count - 1);
						idx = IDX_FIELD_W'(slot);
						gen = slot_generation[slot] - 1;
					end
				end
				2: begin
					// Index at or above the high-water mark.
					if (issued_count < SLOT_COUNT)
						idx = IDX_FIELD_W'($urandom_range(issued_count, SLOT_COUNT - 1));
				end
				default: ;
			endcase
			send_request(OP_FREE, idx, gen);
		end
	endtask

	// Stop offering and wait until every outstanding result has come back.
	task automatic wait_for_outstanding_grants();
		s_tvalid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Handle life cycle and every status, on a fresh pool.
	task automatic test_handle_lifecycle();
		send_request(OP_FREE, 0, 1);                // nothing issued yet
		send_request(OP_ALLOC, '1, '1);             // payload ignored, slot 0
		send_request(OP_ALLOC, 0, 0);               // slot 1
		send_request(OP_FREE, 0, 0);                // even generation
		send_request(OP_FREE, 0, 32'hFFFF_FFFF);
		send_request(OP_FREE, 0, 32'h8000_0001);    // top bit differs
		send_request(OP_FREE, 0, 1);                // good free
		send_request(OP_FREE, 0, 1);                // double free
		send_request(OP_FREE, 0, 2);                // matches but not live
		send_request(OP_FREE, 1023, 1);             // highest index, never issued
		send_request(OP_FREE, 2, 0);                // at the high-water mark
		send_request(OP_FREE, 1, 1);
		send_request(OP_ALLOC, 0, 0);               // reuses slot 1 first
		send_request(OP_ALLOC, 0, 0);               // then slot 0
		send_request(OP_FREE, 0, 1);                // old handle to reused slot
		send_request(OP_ALLOC, '1, 32'h5555_AAAA);  // fresh slot 2
		send_request(OP_FREE, 2, 1);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_FREE, 2, 3);
		send_request(OP_FREE, 1, 3);
		send_request(OP_FREE, 0, 3);
		wait_for_outstanding_grants();
	endtask

	// Mixed random traffic with the pool partly occupied.
	task automatic test_random_traffic();
		repeat (150) send_random_request(50, 35);
		wait_for_outstanding_grants();
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		hold_off_request = 1'b1;
		repeat (40) send_random_request(60, 30);
		wait_for_outstanding_grants();
	endtask

	// Fill every slot, hit the full status, then churn a full pool.
	task automatic test_pool_exhaustion();
		int slot;
		while (!(issued_count == SLOT_COUNT && recycled_count == 0))
			send_random_request(95, 3);
		repeat (4) send_request(OP_ALLOC, IDX_FIELD_W'($urandom), $urandom);
		slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
		send_request(OP_FREE, IDX_FIELD_W'(slot), slot_generation[slot]);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, '1, '1);
		repeat (120) send_random_request(50, 40);
		wait_for_outstanding_grants();
	endtask

	// Receiver: random readiness in segments, plus a long hold-off on demand.
	initial begin : receiver
		int segment_left;
		int ready_pct;
		segment_left = 0;
		ready_pct = 100;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_request = 1'b0;
			end else begin
				if (segment_left == 0) begin
					segment_left = $urandom_range(8, 64);
					case ($urandom_range(0, 2))
						0: ready_pct = 100;
						1: ready_pct = 70;
						default: ready_pct = 25;
					endcase
				end
				segment_left--;
				m_tready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_grants.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected result status=%0d index=%0d gen=%h",
						$realtime, m_tuser, m_tdata[IDX_FIELD_W-1:0],
						m_tdata[IDX_FIELD_W +: GEN_FIELD_W]);
			end else begin
				want = expected_grants.pop_front();
				if (m_tuser !== want.status || m_tdata[IDX_FIELD_W-1:0] !== want.index
						|| m_tdata[IDX_FIELD_W +: GEN_FIELD_W] !== want.generation) begin
					error_count++;
					if (error_count <= 10)
						$display({"%0t: wrong result, expected status=%0d index=%0d gen=%h,",
							" got status=%0d index=%0d gen=%h"}, $realtime,
							want.status, want.index, want.generation, m_tuser,
							m_tdata[IDX_FIELD_W-1:0], m_tdata[IDX_FIELD_W +: GEN_FIELD_W]);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		slot_generation = '{default: '0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_handle_lifecycle();
		test_random_traffic();
		test_output_backpressure();
		test_pool_exhaustion();
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/gsa_pkg.sv
src/gsa_free_stack.sv
src/generational_slot_allocator_core.sv
test/generational_slot_allocator_core_tb.sv
